FILE: rtl/sfr_pkg.sv
// Package for the stream find-and-replace block: sizes, register indexes,
// shared structs and the length clamp function. No dependencies.
package sfr_pkg;

  localparam int BUF_DEPTH = 8;
  localparam int BUF_IDX_W = 3;
  localparam int CNT_W = 4;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 64;

  // Upper limits on the pattern and replacement lengths.
  localparam int PATTERN_MAX = 8;
  localparam int REPLACEMENT_MAX = 8;
  localparam logic [CNT_W-1:0] PAT_LIMIT =
    CNT_W'((PATTERN_MAX < BUF_DEPTH) ? PATTERN_MAX : BUF_DEPTH);
  localparam logic [CNT_W-1:0] REPL_LIMIT =
    CNT_W'((REPLACEMENT_MAX < BUF_DEPTH) ? REPLACEMENT_MAX : BUF_DEPTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 8'd3;

  typedef logic [BUF_DEPTH-1:0][7:0] pend_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_bytes;
    logic [CNT_W-1:0] pattern_length;
    logic [CFG_DATA_W-1:0] replacement_bytes;
    logic [CNT_W-1:0] replacement_length;
  } cfg_t;

  typedef struct packed {
    logic prefix;
    logic full;
  } cmp_t;

  typedef struct packed {
    logic produce;
    logic finish;
    logic [7:0] data;
  } stage_ctl_t;

  // A zero length acts as one; anything above the limit acts as the limit.
  function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] v,
                                                input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] r;
    r = (v == '0) ? CNT_W'(1) : v;
    return (r > lim) ? lim : r;
  endfunction

endpackage

FILE: rtl/sfr_ifs.sv
// Channel interfaces of the stream find-and-replace block: input stream,
// output stream and configuration write channel. Depends on sfr_pkg.
interface sfr_in_if;
  logic valid;
  logic ready;
  logic [7:0] in_byte;
  logic end_of_stream;
  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface sfr_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic last_of_run;
  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface sfr_cfg_if;
  logic valid;
  logic ready;
  logic [sfr_pkg::CFG_IDX_W-1:0] index;
  logic [sfr_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/sfr_cfg_regs.sv
// Configuration register file of the stream find-and-replace block.
// Depends on sfr_pkg and sfr_cfg_if.
module sfr_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  sfr_cfg_if.sink         cfg,
  output sfr_pkg::cfg_t   regs,
  output logic            pattern_write
);
  import sfr_pkg::*;

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr = cfg.valid;
  assign pattern_write = wr && (cfg.index == REG_PATTERN_BYTES ||
                                cfg.index == REG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pattern_bytes <= '0;
      regs.pattern_length <= CNT_W'(1);
      regs.replacement_bytes <= '0;
      regs.replacement_length <= CNT_W'(1);
    end else if (wr) begin
      case (cfg.index)
        REG_PATTERN_BYTES: regs.pattern_bytes <= cfg.data;
        REG_PATTERN_LENGTH: regs.pattern_length <= cfg.data[CNT_W-1:0];
        REG_REPLACEMENT_BYTES: regs.replacement_bytes <= cfg.data;
        REG_REPLACEMENT_LENGTH: regs.replacement_length <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/sfr_prefix_cmp.sv
// Shared compare unit: checks whether the pending bytes are a prefix of the
// pattern and whether they form the whole pattern. Depends on sfr_pkg.
module sfr_prefix_cmp (
  input  sfr_pkg::pend_t              pend,
  input  logic [sfr_pkg::CNT_W-1:0]   count,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] pattern,
  input  logic [sfr_pkg::CNT_W-1:0]   plen,
  output sfr_pkg::cmp_t               res
);
  import sfr_pkg::*;

  logic [BUF_DEPTH-1:0] hit;

  // Each byte position compares on its own; positions past the count pass.
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      hit[i] = (pend[i] == pattern[i*8 +: 8]) || (CNT_W'(i) >= count);
    end
  end

  assign res.prefix = (count <= plen) && (&hit);
  assign res.full = (count == plen) && res.prefix;

endmodule

FILE: rtl/sfr_out_stage.sv
// Result staging: one byte is held back until it is known whether more
// bytes follow for the same input, then moved to the output register.
// Depends on sfr_pkg and sfr_out_if.
module sfr_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  sfr_pkg::stage_ctl_t  ctl,
  output logic                 ok,
  sfr_out_if.source            out_s
);
  import sfr_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       out_valid;
  logic       out_free;
  logic       push;

  assign out_free = !out_valid || out_s.ready;
  assign ok = !stage_valid || out_free;
  assign push = (ctl.produce || ctl.finish) && stage_valid && out_free;
  assign out_s.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_s.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.produce && ok) begin
        stage_valid <= 1'b1;
      end else if (ctl.finish && ok) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_s.out_byte <= stage_byte;
      out_s.last_of_run <= ctl.finish;
    end
    if (ctl.produce && ok) begin
      stage_byte <= ctl.data;
    end
  end

endmodule

FILE: rtl/stream_find_and_replace.sv
// Top level of the stream find-and-replace block: sequencer and pending
// buffer. Depends on sfr_pkg, sfr_ifs, sfr_cfg_regs, sfr_prefix_cmp and
// sfr_out_stage.
//
// Usage: text enters one byte per transaction on in_s, rewritten text leaves
// one byte per transaction on out_s, and cfg writes the pattern, its length,
// the replacement and its length (indexes 0 to 3; other indexes are ignored).
// Every leftmost, non-overlapping occurrence of the pattern is replaced.
// The final output byte caused by an input carries last_of_run; an input that
// may still begin a match causes no output. end_of_stream flushes the bytes
// still held back. Writing the pattern or its length discards them.
// Configuration must be written only while the block is idle; the block
// itself does not enforce it. The block takes one input at a time,
// through accept, the prefix check and a finishing state; each pending byte
// it pushes out past the compare unit adds a shift and another check, and
// replacement and flushed bytes leave one per cycle while the receiver does
// not stall, as the single compare unit and the output stage allow. The first
// output byte of a replacement or flush goes from the check state through the
// staging byte to the output register; a dropped byte goes through the shift.
// Reset (rst, synchronous) empties the pending buffer and the output and
// restores the register defaults. When the receiver stalls, the sequencer
// holds as soon as both its staging byte and the output register are full.
module stream_find_and_replace (
  input  logic       clk,
  input  logic       rst,
  sfr_in_if.sink     in_s,
  sfr_out_if.source  out_s,
  sfr_cfg_if.sink    cfg
);
  import sfr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_REPL  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state;
  pend_t                pend;
  logic [CNT_W-1:0]     count;
  logic                 eos;
  logic [BUF_IDX_W-1:0] idx;

  cfg_t                 regs;
  logic                 pattern_write;
  cmp_t                 cmp;
  stage_ctl_t           sctl;
  logic                 ok;
  logic [CNT_W-1:0]     plen;
  logic [CNT_W-1:0]     rlen;
  logic                 accept;
  logic [BUF_IDX_W-1:0] wpos;

  sfr_cfg_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .regs         (regs),
    .pattern_write(pattern_write)
  );

  assign plen = eff_len(regs.pattern_length, PAT_LIMIT);
  assign rlen = eff_len(regs.replacement_length, REPL_LIMIT);

  // The one compare unit, reused on every pass through the check state.
  sfr_prefix_cmp u_cmp (
    .pend   (pend),
    .count  (count),
    .pattern(regs.pattern_bytes),
    .plen   (plen),
    .res    (cmp)
  );

  sfr_out_stage u_stage (
    .clk  (clk),
    .rst  (rst),
    .ctl  (sctl),
    .ok   (ok),
    .out_s(out_s)
  );

  assign in_s.ready = (state == S_IDLE);
  assign accept = in_s.valid && in_s.ready;
  // A full buffer overwrites its last entry.
  assign wpos = (count >= CNT_W'(BUF_DEPTH)) ? BUF_IDX_W'(BUF_DEPTH - 1)
                                             : count[BUF_IDX_W-1:0];

  always_comb begin
    sctl.produce = 1'b0;
    sctl.finish = 1'b0;
    sctl.data = pend[0];
    case (state)
      S_SHIFT, S_FLUSH: begin
        sctl.produce = 1'b1;
      end
      S_REPL: begin
        sctl.produce = 1'b1;
        sctl.data = regs.replacement_bytes[idx*8 +: 8];
      end
      S_DONE: begin
        sctl.finish = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      eos <= 1'b0;
      idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            count <= CNT_W'(wpos) + CNT_W'(1);
            eos <= in_s.end_of_stream;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (cmp.full) begin
            idx <= '0;
            state <= S_REPL;
          end else if (count == '0 || cmp.prefix) begin
            state <= (eos && count != '0) ? S_FLUSH : S_DONE;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (ok) begin
            count <= count - CNT_W'(1);
            state <= S_CHECK;
          end
        end
        S_FLUSH: begin
          if (ok) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state <= S_DONE;
            end
          end
        end
        S_REPL: begin
          if (ok) begin
            idx <= idx + BUF_IDX_W'(1);
            if ({1'b0, idx} == rlen - CNT_W'(1)) begin
              count <= '0;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // A new pattern discards the bytes held back.
      if (pattern_write) begin
        count <= '0;
      end
    end
  end

  // Pending buffer: written at the fill position, shifted down on each drop.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend[wpos] <= in_s.in_byte;
    end else if ((state == S_SHIFT || state == S_FLUSH) && ok) begin
      for (int i = 0; i < BUF_DEPTH - 1; i++) begin
        pend[i] <= pend[i+1];
      end
    end
  end

endmodule

FILE: dv/sfr_tb_pkg.sv
// Scoreboard for the stream find-and-replace testbench: a predictor of the
// rewritten text and the queue of output bytes still due. Depends on sfr_pkg.
package sfr_tb_pkg;
  import sfr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  class sfr_scoreboard;
    localparam int MAX_PRINTED = 40;

    logic [63:0]  pattern;
    logic [3:0]   pattern_len_reg;
    logic [63:0]  substitute;
    logic [3:0]   substitute_len_reg;
    logic [7:0]   held [BUF_DEPTH];
    int unsigned  held_count;
    text_byte_t   due_q[$];
    int           errors;

    function new();
      pattern = '0;
      pattern_len_reg = 4'd1;
      substitute = '0;
      substitute_len_reg = 4'd1;
      held_count = 0;
      errors = 0;
    endfunction

    // A zero length behaves as one, anything past the limit as the limit.
    function int unsigned clamp_len(logic [3:0] v, int unsigned lim);
      if (v == 4'd0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PATTERN_BYTES: begin
          pattern = value;
          held_count = 0;
        end
        REG_PATTERN_LENGTH: begin
          pattern_len_reg = value[3:0];
          held_count = 0;
        end
        REG_REPLACEMENT_BYTES: substitute = value;
        REG_REPLACEMENT_LENGTH: substitute_len_reg = value[3:0];
        default: ;
      endcase
    endfunction

    function bit held_is_prefix(int unsigned plen);
      if (held_count > plen) return 0;
      for (int i = 0; i < held_count; i++)
        if (held[i] != pattern[8*i +: 8]) return 0;
      return 1;
    endfunction

    // Works out the output bytes that one input byte causes.
    function void note_input(logic [7:0] in_byte, logic eos);
      int unsigned plen;
      int unsigned rlen;
      logic [7:0]  run[$];
      plen = clamp_len(pattern_len_reg, PAT_LIMIT);
      rlen = clamp_len(substitute_len_reg, REPL_LIMIT);
      if (held_count >= BUF_DEPTH) held_count = BUF_DEPTH - 1;
      held[held_count] = in_byte;
      held_count++;
      while (1) begin
        if (held_count == plen && held_is_prefix(plen)) begin
          for (int i = 0; i < rlen; i++) run.push_back(substitute[8*i +: 8]);
          held_count = 0;
          break;
        end
        if (held_count == 0 || held_is_prefix(plen)) break;
        run.push_back(held[0]);
        for (int i = 0; i < BUF_DEPTH - 1; i++) held[i] = held[i+1];
        held_count--;
      end
      if (eos) begin
        for (int i = 0; i < held_count; i++) run.push_back(held[i]);
        held_count = 0;
      end
      foreach (run[k]) due_q.push_back(text_byte_t'({run[k], k == run.size() - 1}));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(logic [7:0] out_byte, logic last);
      text_byte_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected output byte %02h", out_byte));
        return;
      end
      want = due_q.pop_front();
      if (out_byte !== want.data)
        report($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
      if (last !== want.last)
        report($sformatf("last_of_run %b, expected %b", last, want.last));
    endtask

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

endpackage

FILE: dv/tb_top.sv
// Top of the stream find-and-replace testbench: clock, reset, stimulus and
// handshake monitors around the block. Depends on sfr_pkg, sfr_ifs,
// sfr_tb_pkg and the block's RTL.
module tb_top;
  import sfr_pkg::*;
  import sfr_tb_pkg::*;

  // Cycles to wait once no output is due before touching the registers. An
  // input may still be in flight without causing output.
  localparam int SETTLE_CYCLES = 40;
  // Length of the receiver hold-off that fills the block and stalls its input.
  localparam int HOLD_CYCLES = 300;
  // The longest stretch without any transaction in a correct run is the
  // hold-off plus a settle pause. The limit lies far above that, which also
  // covers a receiver stall on each of eight output bytes of one input.
  localparam int WATCHDOG_LIMIT = 4000;
  // The run stops sending after about this many input bytes.
  localparam int ITEM_TARGET = 270;

  logic clk;
  logic rst;

  sfr_in_if  in_ch();
  sfr_out_if out_ch();
  sfr_cfg_if cfg_ch();

  stream_find_and_replace dut (
    .clk   (clk),
    .rst   (rst),
    .in_s  (in_ch),
    .out_s (out_ch),
    .cfg   (cfg_ch)
  );

  sfr_scoreboard sb = new();

  bit          calm = 1'b0;      // no idling on either side when set
  bit          hold_req = 1'b0;  // asks the receiver for one long hold-off
  int          items_sent = 0;
  int          idle_cycles = 0;
  logic [63:0] cur_pattern;
  int unsigned cur_plen;
  logic [7:0]  sym_base;         // base of the small alphabet of this phase
  string       directed_text = "abcabxaabcab";

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Every transaction is taken at the rising edge. Outputs are checked
  // before the inputs of the same edge are noted; an input can never cause
  // output at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.out_byte, out_ch.last_of_run);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        sb.note_input(in_ch.in_byte, in_ch.end_of_stream);
    end
  end

  // The watchdog counts cycles with no transaction on any channel. A missing
  // output byte or a hung handshake ends the run here.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drive_ready(bit level, int cycles);
    repeat (cycles) begin
      @(negedge clk);
      out_ch.ready = level;
    end
  endtask

  // The receiver alternates bursts of stall and accept. A pending hold
  // request turns into one long stall while the sender keeps offering bytes.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        drive_ready(1'b0, HOLD_CYCLES);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        drive_ready(1'b0, $urandom_range(1, 16));
      end else begin
        drive_ready(1'b1, $urandom_range(1, 16));
      end
    end
  end

  // Offers one byte, after an optional gap, and returns at the edge that
  // accepts it. valid stays high so that the next byte can follow directly.
  task automatic send_byte(logic [7:0] b, logic eos);
    if (!calm && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 16)) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.in_byte = b;
    in_ch.end_of_stream = eos;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Stops the input and waits until the block has delivered everything and
  // has had time to finish any byte that causes no output.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic bit stream_end();
    return $urandom_range(0, 19) == 0;
  endfunction

  // Length registers keep only their low four bits; the rest is noise.
  function automatic logic [63:0] len_word(logic [3:0] len);
    logic [63:0] w;
    w = {$urandom, $urandom};
    w[3:0] = len;
    return w;
  endfunction

  // The pattern is drawn mostly from a three-letter alphabet so that the
  // random text hits full and partial matches often. Lengths are usually
  // legal, sometimes anywhere in the four-bit range.
  task automatic new_random_config();
    logic [3:0] plen_reg;
    logic [3:0] rlen_reg;
    sym_base = 8'($urandom);
    for (int k = 0; k < 8; k++) cur_pattern[8*k +: 8] = sym_base + 8'($urandom_range(0, 2));
    if ($urandom_range(0, 4) == 0) cur_pattern = {$urandom, $urandom};
    plen_reg = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    rlen_reg = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    cur_plen = sb.clamp_len(plen_reg, PAT_LIMIT);
    write_reg(REG_PATTERN_BYTES, cur_pattern);
    write_reg(REG_PATTERN_LENGTH, len_word(plen_reg));
    if ($urandom_range(0, 3) != 0) begin
      write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
      write_reg(REG_REPLACEMENT_LENGTH, len_word(rlen_reg));
    end
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_REPLACEMENT_LENGTH + 1, 255)), {$urandom, $urandom});
  endtask

  // Most of a phase is whole patterns and broken-off prefixes; the rest is
  // letters of the alphabet and fully random bytes. Any byte may end a stream.
  task automatic run_phase(int n);
    int target;
    int kind;
    int cut;
    target = items_sent + n;
    while (items_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        for (int k = 0; k < cur_plen; k++) send_byte(cur_pattern[8*k +: 8], stream_end());
      end else if (kind <= 7) begin
        cut = $urandom_range(0, cur_plen - 1);
        for (int k = 0; k < cut; k++) send_byte(cur_pattern[8*k +: 8], stream_end());
        send_byte(sym_base + 8'($urandom_range(0, 3)), stream_end());
      end else if (kind == 8) begin
        send_byte(sym_base + 8'($urandom_range(0, 3)), stream_end());
      end else begin
        send_byte(8'($urandom), stream_end());
      end
    end
  endtask

  initial begin
    int phase;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.end_of_stream = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero lengths act as one: a single zero byte becomes one replacement
    // byte, and a byte that does not match passes through.
    write_reg(REG_PATTERN_LENGTH, '0);
    write_reg(REG_REPLACEMENT_BYTES, 64'hA5);
    write_reg(REG_REPLACEMENT_LENGTH, '0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    // A three-byte pattern: a full match, a prefix broken by a foreign byte
    // that pushes out several bytes at once, a match right after a false
    // start, and a partial match flushed by the end of the stream.
    write_reg(REG_PATTERN_BYTES, 64'h63_62_61);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    write_reg(REG_REPLACEMENT_BYTES, 64'h59_58);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd2);
    for (int i = 0; i < directed_text.len(); i++)
      send_byte(directed_text[i], i == directed_text.len() - 1);

    // Two bytes are left pending, then the pattern is rewritten, which drops
    // them without output. Lengths above the limit act as eight, and writes
    // to unused indexes change nothing.
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    settle();
    write_reg(REG_PATTERN_BYTES, '1);
    write_reg(REG_PATTERN_LENGTH, 64'hF);
    write_reg(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd9);
    write_reg(REG_REPLACEMENT_LENGTH + 8'd1, '1);
    write_reg('1, '0);
    repeat (8) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Random phases, each under a fresh configuration. The third phase runs
    // against the long receiver hold-off; the last stretch has no idling.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      new_random_config();
      if (phase == 2) hold_req = 1'b1;
      if (items_sent >= ITEM_TARGET - 50) calm = 1'b1;
      run_phase($urandom_range(15, 35));
      phase++;
    end
    settle();

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
